>>> src/cct_pkg.sv
`timescale 1ns / 1ps
package cct_pkg;

  localparam int MaxIntervalsDef = 8;
  localparam int MaxImageBytesDef = 32768;
  localparam logic [15:0] HeaderBytes = 16'd12;
  localparam logic [31:0] MagicHwam = {8'h48, 8'h57, 8'h41, 8'h4D};
  localparam int IdxW = 4;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StProtocol = 3'd1,
    StRange    = 3'd2,
    StNoInit   = 3'd3,
    StNoMem    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FsmIdle,
    FsmCheck,
    FsmScan,
    FsmDone
  } fsm_e;

  typedef struct packed {
    logic            vld;
    logic [15:0]     lo;
    logic [15:0]     hi;
    logic            dup;
    logic            hit;
    logic [15:0]     sub;
    logic            free_f;
    logic [IdxW-1:0] free_idx;
  } tok_t;

endpackage

>>> src/cct_cell.sv
`timescale 1ns / 1ps
module cct_cell
  import cct_pkg::*;
#(
  parameter int Index = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clr_i,
  input  logic        wr_i,
  input  logic [15:0] wr_lo_i,
  input  logic [15:0] wr_hi_i,
  input  tok_t        tok_i,
  output tok_t        tok_o
);

  logic        occ_q, occ_d;
  logic [15:0] start_q, end_q;
  tok_t        tok_q, tok_d;
  logic        cont, touch;

  assign cont  = occ_q && (tok_i.lo >= start_q) && (tok_i.hi <= end_q);
  assign touch = occ_q && (tok_i.lo <= end_q) && (tok_i.hi >= start_q);

  always_comb begin
    tok_d = tok_i;
    occ_d = occ_q;
    if (tok_i.vld && !tok_i.dup) begin
      if (cont) begin
        tok_d.dup = 1'b1;
      end else if (touch) begin
        tok_d.lo  = (start_q < tok_i.lo) ? start_q : tok_i.lo;
        tok_d.hi  = (end_q > tok_i.hi) ? end_q : tok_i.hi;
        tok_d.hit = 1'b1;
        tok_d.sub = tok_i.sub + (end_q - start_q);
        occ_d     = 1'b0;
      end
      if (!tok_i.free_f && (!occ_q || (touch && !cont))) begin
        tok_d.free_f   = 1'b1;
        tok_d.free_idx = IdxW'(Index);
      end
    end
    if (wr_i) begin
      occ_d = 1'b1;
    end
    if (clr_i) begin
      occ_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      tok_q <= '0;
    end else begin
      occ_q <= occ_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      start_q <= wr_lo_i;
      end_q   <= wr_hi_i;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> src/chunk_coverage_tracker_top.sv
`timescale 1ns / 1ps
// Chunk coverage tracker. Each input beat on the s_axis channel carries one
// frame header; each header produces exactly one result beat on m_axis with
// the status, the covered byte count and the running counters.
// The user must write the buffer size register via cfg_we_i and cfg_wdata_i
// only while the block is idle, which the block leaves unchecked. A write also
// clears the current transfer. A header that is rejected, not initialized or
// has an empty payload gives its result from the check state. A chunk that
// passes the checks walks a token through the row of MAX_INTERVALS interval
// cells, one cell per cycle, and its result is loaded from the tail register.
// Both load the output register only once it is free.
// The block takes one header at a time; s_axis_tready is high only when no
// header is in work. The result stays in an output register until
// m_axis_tready takes it, and the next header may be accepted meanwhile; its
// processing waits while the output register is still full.
// Reset clears the buffer size, the transfer state, the interval cells and
// all counters.
module chunk_coverage_tracker_top
  import cct_pkg::*;
#(
  parameter int MAX_INTERVALS = MaxIntervalsDef,
  parameter int MAX_IMAGE_BYTES = MaxImageBytesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // frame_length, magic, total_bytes, image_crc, chunk_offset
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, duplicate, received_bytes, coverage_done, expected_crc,
  // chunk_count, rejected_count, duplicate_count, 3 zero bits
  output logic [135:0] m_axis_tdata
);

  localparam int N = MAX_INTERVALS;

  fsm_e         state_q, state_d;
  logic [111:0] hdr_q;
  logic [15:0]  buf_q, ann_tot_q, ann_crc_q, cov_q;
  logic [31:0]  acc_cnt_q, rej_cnt_q, dup_cnt_q;
  logic         out_vld_q;
  logic [135:0] out_q;
  tok_t         tok0_q, tail_q;
  tok_t         chain [N+1];
  logic [N-1:0] wr_vec;
  logic         clr;

  logic [15:0] flen, crc, off, len, new_tot;
  logic [31:0] magic, total;
  logic [16:0] chunk_end;
  logic        out_free, restart, hdr_err, rng_err, early;
  status_e     early_st;

  assign flen  = hdr_q[15:0];
  assign magic = hdr_q[47:16];
  assign total = hdr_q[79:48];
  assign crc   = hdr_q[95:80];
  assign off   = hdr_q[111:96];
  assign len   = flen - HeaderBytes;
  assign chunk_end = {1'b0, off} + {1'b0, len};
  assign out_free = !out_vld_q || m_axis_tready;
  assign restart  = !(ann_tot_q == total[15:0] && ann_crc_q == crc);
  assign new_tot  = restart ? total[15:0] : ann_tot_q;
  assign hdr_err  = (flen < HeaderBytes) || (magic != MagicHwam);
  assign rng_err  = (total == 32'd0) || (total > 32'(MAX_IMAGE_BYTES));

  always_comb begin
    early    = 1'b1;
    early_st = StOk;
    if (hdr_err) begin
      early_st = StProtocol;
    end else if (rng_err) begin
      early_st = StRange;
    end else if (buf_q == 16'd0) begin
      early_st = StNoInit;
    end else if (total > {16'd0, buf_q}) begin
      early_st = StRange;
    end else if (len == 16'd0) begin
      early_st = StOk;
    end else if (chunk_end > {1'b0, new_tot}) begin
      early_st = StRange;
    end else begin
      early = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FsmIdle: begin
        if (s_axis_tvalid) state_d = FsmCheck;
      end
      FsmCheck: begin
        if (out_free) state_d = early ? FsmIdle : FsmScan;
      end
      FsmScan: begin
        if (chain[N].vld) state_d = FsmDone;
      end
      FsmDone: begin
        if (out_free) state_d = FsmIdle;
      end
      default: state_d = FsmIdle;
    endcase
  end

  assign s_axis_tready = (state_q == FsmIdle);

  logic        ann_upd, pass_buf;
  assign pass_buf = !hdr_err && !rng_err && (buf_q != 16'd0) && (total <= {16'd0, buf_q});
  assign ann_upd  = (state_q == FsmCheck) && out_free && pass_buf && restart;
  assign clr      = cfg_we_i || ann_upd;

  logic        done_wr;
  logic [15:0] cov_new;
  assign done_wr = (state_q == FsmDone) && out_free && !tail_q.dup
                   && (tail_q.hit || tail_q.free_f);
  assign cov_new = cov_q + (tail_q.hi - tail_q.lo) - tail_q.sub;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      wr_vec[k] = done_wr && (tail_q.free_idx == IdxW'(k));
    end
  end

  assign chain[0] = tok0_q;
  for (genvar g = 0; g < N; g++) begin : g_cell
    cct_cell #(.Index(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clr_i   (clr),
      .wr_i    (wr_vec[g]),
      .wr_lo_i (tail_q.lo),
      .wr_hi_i (tail_q.hi),
      .tok_i   (chain[g]),
      .tok_o   (chain[g+1])
    );
  end

  // Result fields as they stand after the current update.
  logic [15:0] r_tot, r_crc, r_cov;
  logic [31:0] r_acc, r_rej, r_dup;
  status_e     r_st;
  logic        r_dupf, load;

  always_comb begin
    r_tot  = ann_tot_q;
    r_crc  = ann_crc_q;
    r_cov  = cov_q;
    r_acc  = acc_cnt_q;
    r_rej  = rej_cnt_q;
    r_dup  = dup_cnt_q;
    r_st   = StOk;
    r_dupf = 1'b0;
    load   = 1'b0;
    if (state_q == FsmCheck && out_free) begin
      if (pass_buf && restart) begin
        r_tot = total[15:0];
        r_crc = crc;
        r_cov = 16'd0;
      end
      if (early) begin
        load = 1'b1;
        r_st = early_st;
        if (hdr_err || rng_err || (pass_buf && len != 16'd0)) r_rej = rej_cnt_q + 32'd1;
      end else begin
        r_acc = acc_cnt_q + 32'd1;
      end
    end else if (state_q == FsmDone && out_free) begin
      load = 1'b1;
      if (tail_q.dup) begin
        r_dupf = 1'b1;
        r_dup  = dup_cnt_q + 32'd1;
      end else if (!tail_q.hit && !tail_q.free_f) begin
        r_st  = StNoMem;
        r_rej = rej_cnt_q + 32'd1;
      end else begin
        r_cov = cov_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FsmIdle;
      buf_q      <= 16'd0;
      ann_tot_q  <= 16'd0;
      ann_crc_q  <= 16'd0;
      cov_q      <= 16'd0;
      acc_cnt_q  <= 32'd0;
      rej_cnt_q  <= 32'd0;
      dup_cnt_q  <= 32'd0;
      out_vld_q  <= 1'b0;
      tok0_q     <= '0;
    end else begin
      state_q    <= state_d;
      acc_cnt_q  <= r_acc;
      rej_cnt_q  <= r_rej;
      dup_cnt_q  <= r_dup;
      tok0_q.vld      <= (state_q == FsmCheck) && out_free && !early;
      tok0_q.lo       <= off;
      tok0_q.hi       <= chunk_end[15:0];
      tok0_q.dup      <= 1'b0;
      tok0_q.hit      <= 1'b0;
      tok0_q.sub      <= 16'd0;
      tok0_q.free_f   <= 1'b0;
      tok0_q.free_idx <= '0;
      if (cfg_we_i) begin
        buf_q     <= cfg_wdata_i;
        ann_tot_q <= 16'd0;
        ann_crc_q <= 16'd0;
        cov_q     <= 16'd0;
      end else begin
        ann_tot_q <= r_tot;
        ann_crc_q <= r_crc;
        cov_q     <= r_cov;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) hdr_q <= s_axis_tdata;
    if (chain[N].vld) tail_q <= chain[N];
    if (load) begin
      out_q <= {3'd0, r_dup, r_rej, r_acc, r_crc,
                (r_tot != 16'd0) && (r_cov == r_tot), r_cov, r_dupf, r_st};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

>>> src/cct_checker.sv
`timescale 1ns / 1ps
module cct_checker
  import cct_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second header taken while one is in work");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= StNoMem)
    else $error("status code out of range");

  a_dup_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3]
      |-> m_axis_tdata[2:0] == StOk && m_axis_tdata[19:4] != 16'd0)
    else $error("duplicate flag with bad status or no coverage");

endmodule

bind chunk_coverage_tracker_top cct_checker u_cct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import cct_pkg::*;

  localparam int MaxIv = 8;
  localparam int LimitCycles = 400000;

  typedef struct packed {
    logic [15:0] chunk_offset;
    logic [15:0] image_crc;
    logic [31:0] total_bytes;
    logic [31:0] magic;
    logic [15:0] frame_length;
  } header_t;

  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] duplicate_count;
    logic [31:0] rejected_count;
    logic [31:0] chunk_count;
    logic [15:0] expected_crc;
    logic        coverage_done;
    logic [15:0] received_bytes;
    logic        duplicate;
    status_e     status;
  } summary_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;

  chunk_coverage_tracker_top i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  header_t header_queue[$];
  summary_t summary_queue[$];
  int errors = 0;
  int results_seen = 0;
  int cycle_count = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_count = 0;

  logic [15:0] buf_size;
  logic [15:0] ann_total, ann_crc, covered;
  int iv_count;
  logic [15:0] iv_lo[MaxIv];
  logic [15:0] iv_hi[MaxIv];
  logic [31:0] n_accept, n_reject, n_dup;

  function automatic void clear_transfer();
    ann_total = '0;
    ann_crc = '0;
    covered = '0;
    iv_count = 0;
  endfunction

  function automatic status_e merge_chunk(input int lo, input int hi, output logic dup);
    int n, slot, j, a, b, ml, mh, cov, ns, ne, nl, nh;
    n = iv_count;
    dup = 1'b0;
    for (int i = 0; i < n; i++) begin
      a = iv_lo[i];
      b = iv_hi[i];
      if (lo >= a && hi <= b) begin
        n_dup++;
        dup = 1'b1;
        return StOk;
      end
      if (lo <= b && hi >= a) begin
        ml = lo < a ? lo : a;
        mh = hi > b ? hi : b;
        cov = covered + (mh - ml) - (b - a);
        slot = i;
        j = 0;
        while (j < n) begin
          if (j != slot && iv_lo[j] <= mh && iv_hi[j] >= ml) begin
            ns = iv_lo[j];
            ne = iv_hi[j];
            nl = ns < ml ? ns : ml;
            nh = ne > mh ? ne : mh;
            cov = cov + (nh - nl) - (mh - ml) - (ne - ns);
            ml = nl;
            mh = nh;
            n--;
            iv_lo[j] = iv_lo[n];
            iv_hi[j] = iv_hi[n];
            if (slot == n) slot = j;
          end else begin
            j++;
          end
        end
        iv_lo[slot] = ml;
        iv_hi[slot] = mh;
        iv_count = n;
        covered = cov[15:0];
        return StOk;
      end
    end
    if (n >= MaxIv) begin
      n_reject++;
      return StNoMem;
    end
    iv_lo[n] = lo;
    iv_hi[n] = hi;
    iv_count = n + 1;
    covered = covered + 16'(hi - lo);
    return StOk;
  endfunction

  function automatic summary_t track_header(input header_t h);
    summary_t s;
    status_e st;
    logic dup;
    int len, fin;
    dup = 1'b0;
    if (h.frame_length < 12 || h.magic != MagicHwam) begin
      n_reject++;
      st = StProtocol;
    end else if (h.total_bytes == 0 || h.total_bytes > 32768) begin
      n_reject++;
      st = StRange;
    end else if (buf_size == 0) begin
      st = StNoInit;
    end else if (h.total_bytes > buf_size) begin
      st = StRange;
    end else begin
      if (!(ann_total == h.total_bytes && ann_crc == h.image_crc)) begin
        clear_transfer();
        ann_total = h.total_bytes[15:0];
        ann_crc = h.image_crc;
      end
      len = h.frame_length - 12;
      fin = h.chunk_offset + len;
      if (len == 0) begin
        st = StOk;
      end else if (fin > ann_total) begin
        n_reject++;
        st = StRange;
      end else begin
        n_accept++;
        st = merge_chunk(h.chunk_offset, fin, dup);
      end
    end
    s = '0;
    s.status = st;
    s.duplicate = dup;
    s.received_bytes = covered;
    s.coverage_done = (ann_total != 0 && covered == ann_total);
    s.expected_crc = ann_crc;
    s.chunk_count = n_accept;
    s.rejected_count = n_reject;
    s.duplicate_count = n_dup;
    return s;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got, want);
  endtask

  // Driver: bursts with random gaps.
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        summary_queue.push_back(track_header(header_t'(s_axis_tdata)));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (header_queue.size() > 0) begin
          s_axis_tdata <= header_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, counted here once requested.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_count++;
      if (hold_count >= 300) hold_done = 1'b1;
    end
  end

  // Monitor and receiver stall pattern.
  int stall_phase = 0;
  always @(posedge clk_i) begin
    summary_t got, want;
    if (rst_ni) begin
      cycle_count++;
      if (m_axis_tvalid && m_axis_tready) begin
        got = summary_t'(m_axis_tdata);
        if (summary_queue.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          want = summary_queue.pop_front();
          if (got.status != want.status) report("status", got.status, want.status);
          if (got.duplicate != want.duplicate) report("duplicate", got.duplicate, want.duplicate);
          if (got.received_bytes != want.received_bytes)
            report("received_bytes", got.received_bytes, want.received_bytes);
          if (got.coverage_done != want.coverage_done)
            report("coverage_done", got.coverage_done, want.coverage_done);
          if (got.expected_crc != want.expected_crc)
            report("expected_crc", got.expected_crc, want.expected_crc);
          if (got.chunk_count != want.chunk_count)
            report("chunk_count", got.chunk_count, want.chunk_count);
          if (got.rejected_count != want.rejected_count)
            report("rejected_count", got.rejected_count, want.rejected_count);
          if (got.duplicate_count != want.duplicate_count)
            report("duplicate_count", got.duplicate_count, want.duplicate_count);
        end
        results_seen++;
      end
      stall_phase = (stall_phase + 1) % 64;
      if (hold_req && !hold_done) m_axis_tready <= 1'b0;
      else if (stall_phase < 20) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 2) != 0);
      if (cycle_count > LimitCycles) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("testbench failed");
        $finish;
      end
    end
  end

  function automatic header_t make_header(input int flen, input logic [31:0] mg,
                                          input logic [31:0] tot, input int crc,
                                          input int off);
    header_t h;
    h.frame_length = flen[15:0];
    h.magic = mg;
    h.total_bytes = tot;
    h.image_crc = crc[15:0];
    h.chunk_offset = off[15:0];
    return h;
  endfunction

  task automatic wait_drained();
    while (header_queue.size() > 0 || s_axis_tvalid || summary_queue.size() > 0)
      @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_buffer_size(input logic [15:0] v);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    buf_size = v;
    clear_transfer();
  endtask

  header_t h;
  int tot, crc, off, len, kind;
  initial begin
    buf_size = '0;
    clear_transfer();
    n_accept = '0;
    n_reject = '0;
    n_dup = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    header_queue.push_back(make_header(100, MagicHwam, 1000, 16'h1234, 0));
    header_queue.push_back(make_header(11, MagicHwam, 1000, 1, 0));
    header_queue.push_back(make_header(20, 32'h4857414C, 1000, 1, 0));
    header_queue.push_back(make_header(20, MagicHwam, 0, 1, 0));
    header_queue.push_back(make_header(20, MagicHwam, 32769, 1, 0));
    header_queue.push_back(make_header(65535, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 65535));
    write_buffer_size(16'hFFFF);
    header_queue.push_back(make_header(12, MagicHwam, 32768, 16'hFFFF, 65535));
    header_queue.push_back(make_header(22, MagicHwam, 32768, 16'hFFFF, 32758));
    header_queue.push_back(make_header(22, MagicHwam, 32768, 16'hFFFF, 32759));
    header_queue.push_back(make_header(22, MagicHwam, 32768, 16'hFFFF, 0));
    header_queue.push_back(make_header(16, MagicHwam, 32768, 16'hFFFF, 2));
    header_queue.push_back(make_header(22, MagicHwam, 32768, 16'hFFFF, 10));
    for (int i = 0; i < 9; i++)
      header_queue.push_back(make_header(14, MagicHwam, 32768, 16'hFFFF, 100 + 10 * i));
    header_queue.push_back(make_header(12 + 32768, MagicHwam, 32768, 16'hFFFF, 0));
    write_buffer_size(16'd100);
    header_queue.push_back(make_header(20, MagicHwam, 101, 5, 0));
    header_queue.push_back(make_header(112, MagicHwam, 100, 5, 0));
    header_queue.push_back(make_header(13, MagicHwam, 100, 6, 99));

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_buffer_size(16'd64);
        1: write_buffer_size(16'd1);
        2: write_buffer_size(16'd0);
        3: write_buffer_size(16'd32768);
        4: write_buffer_size(16'(($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h8000));
        default: write_buffer_size(16'($urandom_range(1, 65535)));
      endcase
      if (phase == 3) begin
        wait_drained();
        hold_req = 1'b1;
      end
      tot = (buf_size == 0) ? 64 : $urandom_range(1, (buf_size > 200) ? 200 : buf_size);
      crc = $urandom_range(0, 65535);
      for (int k = 0; k < 250; k++) begin
        if ($urandom_range(0, 40) == 0) begin
          tot = $urandom_range(1, 200);
          crc = $urandom_range(0, 65535);
        end
        kind = $urandom_range(0, 19);
        len = $urandom_range(0, (tot > 40) ? 40 : tot);
        off = $urandom_range(0, tot);
        if (kind == 0) begin
          h = make_header($urandom_range(0, 65535), $urandom, $urandom, $urandom, $urandom);
        end else if (kind == 1) begin
          h = make_header($urandom_range(0, 11), MagicHwam, tot, crc, off);
        end else if (kind == 2) begin
          h = make_header(12 + len, MagicHwam ^ (32'h1 << $urandom_range(0, 31)), tot, crc, off);
        end else if (kind == 3) begin
          h = make_header(12 + len, MagicHwam, $urandom_range(0, 1) ? 0 : $urandom, crc, off);
        end else if (kind == 4) begin
          h = make_header(12 + len, MagicHwam, tot, crc, $urandom_range(0, 65535));
        end else if (kind == 5) begin
          h = make_header($urandom_range(12, 65535), MagicHwam, 32768, crc, $urandom_range(0, 65535));
        end else begin
          h = make_header(12 + len, MagicHwam, tot, crc, off);
        end
        header_queue.push_back(h);
        if (phase == 4 && k == 125) wait_drained();
        while (header_queue.size() > 8) @(posedge clk_i);
      end
    end
    wait_drained();
    $display("covered %0d results: header errors, range and buffer limits, merges, full lists",
             results_seen);
    $display("counters at end: accepted %0d rejected %0d duplicate %0d",
             n_accept, n_reject, n_dup);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
